// ===== design/rx_ring_buffer_line_detect_macros.svh =====
// Assertion macros shared by the receive ring buffer modules.
`ifndef RX_RING_BUFFER_LINE_DETECT_MACROS_SVH
`define RX_RING_BUFFER_LINE_DETECT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define RXRB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rxrb assertion failed");

// Next-cycle implication, disabled during reset.
`define RXRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rxrb assertion failed");

`else

`define RXRB_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RXRB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/rxrb_pkg.sv =====
// Types and constants for the receive ring buffer with line detection.
`timescale 1ns / 1ps

package rxrb_pkg;

   localparam logic [1:0] ACT_PUSH  = 2'd0;
   localparam logic [1:0] ACT_POP   = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   localparam logic [7:0] LINE_DELIM_RESET = 8'd10;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] byte_in;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       byte_out_valid;
      logic [7:0] bytes_held;
      logic [7:0] line_length;
      logic       overflow_flag;
   } rsp_type;

   typedef struct packed {
      logic latch;
      logic exec;
      logic init;
      logic scan;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
   } status_type;

endpackage

// ===== design/rxrb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rxrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/rxrb_ctrl.sv =====
// Sequencer for one word: execute, set up scan, scan, hand off the result.
`timescale 1ns / 1ps
`include "rx_ring_buffer_line_detect_macros.svh"

module rxrb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  rxrb_pkg::status_type status,
   output rxrb_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_INIT,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_INIT;
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output word is free
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `RXRB_ASSERT_NEXT(a_exec_then_init, clock, reset, state_ff == ST_EXEC, state_ff == ST_INIT)
   `RXRB_ASSERT_IMPLY(a_load_slot_free, clock, reset, cmd.rsp_load, slot_free)
   `RXRB_ASSERT_NEXT(a_load_shows_rsp, clock, reset, cmd.rsp_load, rsp_valid_ff)

endmodule

// ===== design/rxrb_dpath.sv =====
// Datapath: indices, byte count, overflow flag, delimiter scan and result word.
`timescale 1ns / 1ps
`include "rx_ring_buffer_line_detect_macros.svh"

module rxrb_dpath #(
   parameter int DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rxrb_pkg::req_type    req_data,
   input  logic                 csr_we,
   input  logic [7:0]           csr_wdata,
   input  rxrb_pkg::cmd_type    cmd,
   output rxrb_pkg::status_type status,
   output rxrb_pkg::rsp_type    rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int XW = (AW > 8) ? AW : 8;
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] idx);
      wrap_next = (idx == LAST) ? '0 : idx + AW'(1);
   endfunction

   function automatic logic [7:0] sat8(input logic [AW-1:0] v);
      logic [XW-1:0] x;
      x    = XW'(v);
      sat8 = (x > XW'(255)) ? 8'hFF : x[7:0];
   endfunction

   logic [1:0]      act_ff;
   logic [7:0]      byte_ff;
   logic [AW-1:0]   rd_idx_ff, rd_idx_in;
   logic [AW-1:0]   wr_idx_ff, wr_idx_in;
   logic [AW-1:0]   count_ff, count_in;
   logic            dropped_ff, dropped_in;
   logic [7:0]      delim_ff;
   logic            pop_ok_ff;
   logic [7:0]      byte_out_ff;
   logic [AW-1:0]   scan_addr_ff;
   logic [AW-1:0]   issued_ff;
   logic [AW-1:0]   checked_ff;
   logic            pend_ff;
   logic [AW-1:0]   line_len_ff;
   rxrb_pkg::rsp_type rsp_ff;

   logic            ram_we;
   logic [AW-1:0]   ram_raddr;
   logic [7:0]      ram_rdata;
   logic            full, empty, issue, hit;

   assign full  = (count_ff == LAST);
   assign empty = (count_ff == '0);

   assign ram_we    = cmd.exec && (act_ff == rxrb_pkg::ACT_PUSH) && !full;
   assign ram_raddr = cmd.scan ? scan_addr_ff : rd_idx_ff;

   rxrb_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_idx_ff),
      .wr_data (byte_ff),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // at most one read issued and one byte checked per scan cycle
   assign issue = cmd.scan && (issued_ff != count_ff);
   assign hit   = cmd.scan && pend_ff && !dropped_ff && (ram_rdata == delim_ff);
   assign status.scan_done = cmd.scan &&
                             (dropped_ff || hit || (!pend_ff && (issued_ff == count_ff)));

   always_comb begin
      rd_idx_in  = rd_idx_ff;
      wr_idx_in  = wr_idx_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (cmd.exec) begin
         case (act_ff)
            rxrb_pkg::ACT_PUSH: begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  wr_idx_in = wrap_next(wr_idx_ff);
                  count_in  = count_ff + AW'(1);
               end
            end
            rxrb_pkg::ACT_POP: begin
               if (!empty) begin
                  rd_idx_in = wrap_next(rd_idx_ff);
                  count_in  = count_ff - AW'(1);
               end
            end
            rxrb_pkg::ACT_CLEAR: begin
               rd_idx_in  = '0;
               wr_idx_in  = '0;
               count_in   = '0;
               dropped_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff  <= '0;
         wr_idx_ff  <= '0;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         delim_ff   <= rxrb_pkg::LINE_DELIM_RESET;
         pend_ff    <= 1'b0;
      end else begin
         rd_idx_ff  <= rd_idx_in;
         wr_idx_ff  <= wr_idx_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         if (csr_we) begin
            delim_ff <= csr_wdata;
         end
         if (cmd.init) begin
            pend_ff <= 1'b0;
         end else if (cmd.scan) begin
            pend_ff <= issue;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         act_ff  <= req_data.action;
         byte_ff <= req_data.byte_in;
      end
      if (cmd.exec) begin
         pop_ok_ff <= (act_ff == rxrb_pkg::ACT_POP) && !empty;
      end
      if (cmd.init) begin
         // popped byte arrives from the read issued during execute
         byte_out_ff  <= pop_ok_ff ? ram_rdata : 8'd0;
         scan_addr_ff <= rd_idx_ff;
         issued_ff    <= '0;
         checked_ff   <= '0;
         line_len_ff  <= '0;
      end
      if (issue) begin
         scan_addr_ff <= wrap_next(scan_addr_ff);
         issued_ff    <= issued_ff + AW'(1);
      end
      if (cmd.scan && pend_ff) begin
         checked_ff <= checked_ff + AW'(1);
      end
      if (hit) begin
         line_len_ff <= checked_ff + AW'(1);
      end
      if (cmd.rsp_load) begin
         rsp_ff.byte_out       <= byte_out_ff;
         rsp_ff.byte_out_valid <= pop_ok_ff;
         rsp_ff.bytes_held     <= sat8(count_ff);
         rsp_ff.line_length    <= sat8(line_len_ff);
         rsp_ff.overflow_flag  <= dropped_ff;
      end
   end

   assign rsp_data = rsp_ff;

   `RXRB_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= LAST)
   `RXRB_ASSERT_IMPLY(a_issue_bound, clock, reset, cmd.scan, issued_ff <= count_ff)
   `RXRB_ASSERT_IMPLY(a_ovf_no_line, clock, reset, cmd.rsp_load && dropped_ff, line_len_ff == '0)

endmodule

// ===== design/rx_ring_buffer_line_detect.sv =====
// After a word is accepted it passes the execute, scan set-up, scan and done states. The
// delimiter scan reads one stored byte per cycle, over the bytes held after the word, through
// the single read port of the byte store; rsp_valid rises once the output register is free.
// One word is in work at a time: the next word is taken only after its result is loaded, so a
// delimiter or overflow ending the scan brings it sooner and any output stall delays it.
// Reset clears indices, count and overflow and sets the delimiter to newline; no clearing pass.
`timescale 1ns / 1ps

module rx_ring_buffer_line_detect #(
   parameter int DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rxrb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rxrb_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_wdata
);

   rxrb_pkg::cmd_type    cmd;
   rxrb_pkg::status_type status;

   assign csr_ready = 1'b1;

   rxrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rxrb_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule
